// File: hw/rtl/ats_pkg.sv
// Shared types, status codes and default sizes for the alias table sampler.
package ats_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_WEIGHT_BITS = 32;
    localparam int DEF_FRAC_BITS   = 32;

    typedef logic [2:0] status_t;

    localparam status_t ST_DRAW_OK    = 3'd0;
    localparam status_t ST_BUILD_DONE = 3'd1;
    localparam status_t ST_ALL_ZERO   = 3'd2;
    localparam status_t ST_NO_TABLE   = 3'd3;
    localparam status_t ST_DROPPED    = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

endpackage

// File: hw/rtl/alias_table_sampler.sv
// Alias table sampler: weight loading, table build sequencer and draw path.
// Load: the weight is stored on start. Draw: the column is registered, read from the stores, then compared.
// Build: per entry a multiply and a division in the shared bit-serial divider, then a sort onto
// the small and large stacks, the pairing and the leftover writes.
// busy is high while an item is at work; each result shows for one cycle on strobe, no stall.
// Reset (rst_n, asynchronous) clears count, total and table state; stores are not cleared.
module alias_table_sampler
    import ats_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             cmd,
    input  logic [WEIGHT_BITS-1:0]           weight,
    input  logic                             last,
    input  logic [31:0]                      ran1,
    input  logic [31:0]                      ran2,
    output logic                             strobe,
    output logic [$clog2(MAX_ENTRIES)-1:0]   sample_index,
    output status_t                          status
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int MASS_W = CNT_W + FRAC_BITS;
    localparam int PROB_W = FRAC_BITS + 1;
    localparam int TOT_W  = WEIGHT_BITS + IDX_W;
    localparam int PROD_W = WEIGHT_BITS + CNT_W;
    localparam logic [MASS_W-1:0] ONE = MASS_W'(1) << FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_DRAW_RD, S_DRAW_CMP,
        S_W_RD, S_W_MUL, S_W_DIV, S_W_WAIT,
        S_C_RD, S_C_CMP,
        S_P_POP, S_P_RDA, S_P_RDG, S_P_UPD,
        S_L_POP, S_L_WR, S_S_POP, S_S_WR
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic               valid_reg, valid_next;
    logic               closed_reg, closed_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   ns_reg, ns_next;
    logic [CNT_W-1:0]   nl_reg, nl_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [IDX_W-1:0]   a_reg, a_next;
    logic [IDX_W-1:0]   g_reg, g_next;
    logic [MASS_W-1:0]  ma_reg, ma_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [FRAC_BITS-1:0] r2_reg, r2_next;
    logic               strobe_reg, strobe_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    status_t            status_reg, status_next;

    // memories
    logic [WEIGHT_BITS-1:0] ws_mem [MAX_ENTRIES];
    logic [MASS_W-1:0]      mass_mem [MAX_ENTRIES];
    logic [PROB_W-1:0]      prob_mem [MAX_ENTRIES];
    logic [IDX_W-1:0]       alias_mem [MAX_ENTRIES];
    logic [IDX_W-1:0]       small_mem [MAX_ENTRIES];
    logic [IDX_W-1:0]       large_mem [MAX_ENTRIES];

    logic                   ws_we, mass_we, pa_we, sm_we, lg_we;
    logic [IDX_W-1:0]       ws_wa, ws_ra, mass_wa, mass_ra, pa_wa, pa_ra;
    logic [IDX_W-1:0]       sm_wa, sm_ra, lg_wa, lg_ra;
    logic [WEIGHT_BITS-1:0] ws_wd, ws_rd;
    logic [MASS_W-1:0]      mass_wd, mass_rd;
    logic [PROB_W-1:0]      prob_wd, prob_rd;
    logic [IDX_W-1:0]       alias_wd, alias_rd, sm_wd, sm_rd, lg_wd, lg_rd;

    // divider
    logic               div_start, div_done;
    logic [MASS_W-1:0]  div_quo;

    // combinational helpers
    logic [CNT_W-1:0]   cnt_eff;
    logic [TOT_W-1:0]   total_eff, total_sum;
    logic [CNT_W+31:0]  col_prod;
    logic [CNT_W-1:0]   col_raw;
    logic [MASS_W-1:0]  new_g;
    logic [FRAC_BITS-1:0] r2_align;

    ats_div #(
        .HI_W  (WEIGHT_BITS),
        .DEN_W (TOT_W),
        .Q_W   (MASS_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (prod_reg[PROD_W-1:CNT_W]),
        .num_lo ({prod_reg[CNT_W-1:0], {FRAC_BITS{1'b0}}}),
        .den    (total_reg),
        .done   (div_done),
        .quo    (div_quo)
    );

    // align ran2 to the fraction width
    generate
        if (FRAC_BITS >= 32)
        begin : g_r2_wide
            assign r2_align = FRAC_BITS'(ran2) << (FRAC_BITS - 32);
        end
        else
        begin : g_r2_narrow
            assign r2_align = FRAC_BITS'(ran2 >> (32 - FRAC_BITS));
        end
    endgenerate

    assign cnt_eff   = closed_reg ? '0 : cnt_reg;
    assign total_eff = closed_reg ? '0 : total_reg;
    assign total_sum = total_eff + TOT_W'(weight);
    assign col_prod  = cnt_reg * ran1;
    assign col_raw   = col_prod[CNT_W+31:32];
    assign new_g     = mass_rd + ma_reg - ONE;

    // sequencer next state and memory control
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        valid_next  = valid_reg;
        closed_next = closed_reg;
        idx_next    = idx_reg;
        ns_next     = ns_reg;
        nl_next     = nl_reg;
        prod_next   = prod_reg;
        a_next      = a_reg;
        g_next      = g_reg;
        ma_next     = ma_reg;
        col_next    = col_reg;
        r2_next     = r2_reg;
        strobe_next = 1'b0;
        index_next  = '0;
        status_next = status_reg;

        ws_we = 1'b0;  ws_wa = cnt_eff[IDX_W-1:0];  ws_wd = weight;
        ws_ra = idx_reg[IDX_W-1:0];
        mass_we = 1'b0;  mass_wa = idx_reg[IDX_W-1:0];  mass_wd = div_quo;
        mass_ra = '0;
        pa_we = 1'b0;  pa_wa = a_reg;  prob_wd = ma_reg[PROB_W-1:0];  alias_wd = g_reg;
        pa_ra = col_reg;
        sm_we = 1'b0;  sm_wa = ns_reg[IDX_W-1:0];  sm_wd = '0;
        sm_ra = IDX_W'(ns_reg - 1'b1);
        lg_we = 1'b0;  lg_wa = nl_reg[IDX_W-1:0];  lg_wd = '0;
        lg_ra = IDX_W'(nl_reg - 1'b1);
        div_start = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start && cmd == CMD_LOAD)
                begin
                    // open a new set after a last load, then store the weight if there is room
                    closed_next = 1'b0;
                    if (closed_reg)
                        valid_next = 1'b0;
                    cnt_next   = cnt_eff;
                    total_next = total_eff;
                    if (cnt_eff < CNT_W'(MAX_ENTRIES))
                    begin
                        ws_we      = 1'b1;
                        cnt_next   = cnt_eff + 1'b1;
                        total_next = total_sum;
                    end
                    if (last)
                    begin
                        closed_next = 1'b1;
                        if ((cnt_eff < CNT_W'(MAX_ENTRIES) ? total_sum : total_eff) == '0)
                        begin
                            valid_next  = 1'b0;
                            strobe_next = 1'b1;
                            status_next = ST_ALL_ZERO;
                        end
                        else
                        begin
                            valid_next = 1'b0;
                            idx_next   = '0;
                            ns_next    = '0;
                            nl_next    = '0;
                            state_next = S_W_RD;
                        end
                    end
                    else if (!(cnt_eff < CNT_W'(MAX_ENTRIES)))
                    begin
                        strobe_next = 1'b1;
                        status_next = ST_DROPPED;
                    end
                end
                else if (start && cmd == CMD_DRAW)
                begin
                    if (!valid_reg || cnt_reg == '0)
                    begin
                        strobe_next = 1'b1;
                        status_next = ST_NO_TABLE;
                    end
                    else
                    begin
                        col_next   = (col_raw >= cnt_reg) ? IDX_W'(cnt_reg - 1'b1)
                                                          : col_raw[IDX_W-1:0];
                        r2_next    = r2_align;
                        state_next = S_DRAW_RD;
                    end
                end
            end
            S_DRAW_RD:
            begin
                state_next = S_DRAW_CMP;
            end
            S_DRAW_CMP:
            begin
                strobe_next = 1'b1;
                status_next = ST_DRAW_OK;
                index_next  = ({1'b0, r2_reg} < prob_rd) ? col_reg : alias_rd;
                state_next  = S_IDLE;
            end
            S_W_RD:
            begin
                state_next = S_W_MUL;
            end
            S_W_MUL:
            begin
                prod_next  = PROD_W'(ws_rd) * PROD_W'(cnt_reg);
                state_next = S_W_DIV;
            end
            S_W_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_W_WAIT;
            end
            S_W_WAIT:
            begin
                if (div_done)
                begin
                    mass_we  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == cnt_reg)
                    begin
                        idx_next   = cnt_reg;
                        state_next = S_C_RD;
                    end
                    else
                        state_next = S_W_RD;
                end
            end
            S_C_RD:
            begin
                mass_ra    = IDX_W'(idx_reg - 1'b1);
                state_next = S_C_CMP;
            end
            S_C_CMP:
            begin
                // sort in descending index order onto the two stacks
                if (mass_rd < ONE)
                begin
                    sm_we   = 1'b1;
                    sm_wd   = IDX_W'(idx_reg - 1'b1);
                    ns_next = ns_reg + 1'b1;
                end
                else
                begin
                    lg_we   = 1'b1;
                    lg_wd   = IDX_W'(idx_reg - 1'b1);
                    nl_next = nl_reg + 1'b1;
                end
                idx_next   = idx_reg - 1'b1;
                state_next = (idx_reg == CNT_W'(1)) ? S_P_POP : S_C_RD;
            end
            S_P_POP:
            begin
                if (ns_reg == '0 || nl_reg == '0)
                    state_next = S_L_POP;
                else
                begin
                    ns_next    = ns_reg - 1'b1;
                    nl_next    = nl_reg - 1'b1;
                    state_next = S_P_RDA;
                end
            end
            S_P_RDA:
            begin
                a_next     = sm_rd;
                g_next     = lg_rd;
                mass_ra    = sm_rd;
                state_next = S_P_RDG;
            end
            S_P_RDG:
            begin
                ma_next    = mass_rd;
                mass_ra    = g_reg;
                state_next = S_P_UPD;
            end
            S_P_UPD:
            begin
                // settle the small column and return the remainder of the large one
                pa_we   = 1'b1;
                mass_we = 1'b1;
                mass_wa = g_reg;
                mass_wd = new_g;
                if (new_g < ONE)
                begin
                    sm_we   = 1'b1;
                    sm_wd   = g_reg;
                    ns_next = ns_reg + 1'b1;
                end
                else
                begin
                    lg_we   = 1'b1;
                    lg_wd   = g_reg;
                    nl_next = nl_reg + 1'b1;
                end
                state_next = S_P_POP;
            end
            S_L_POP:
            begin
                if (nl_reg == '0)
                    state_next = S_S_POP;
                else
                begin
                    nl_next    = nl_reg - 1'b1;
                    state_next = S_L_WR;
                end
            end
            S_L_WR:
            begin
                pa_we      = 1'b1;
                pa_wa      = lg_rd;
                prob_wd    = ONE[PROB_W-1:0];
                alias_wd   = lg_rd;
                state_next = S_L_POP;
            end
            S_S_POP:
            begin
                if (ns_reg == '0)
                begin
                    valid_next  = 1'b1;
                    strobe_next = 1'b1;
                    status_next = ST_BUILD_DONE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ns_next    = ns_reg - 1'b1;
                    state_next = S_S_WR;
                end
            end
            S_S_WR:
            begin
                pa_we      = 1'b1;
                pa_wa      = sm_rd;
                prob_wd    = ONE[PROB_W-1:0];
                alias_wd   = sm_rd;
                state_next = S_S_POP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            total_reg  <= '0;
            valid_reg  <= 1'b0;
            closed_reg <= 1'b0;
            idx_reg    <= '0;
            ns_reg     <= '0;
            nl_reg     <= '0;
            strobe_reg <= 1'b0;
            index_reg  <= '0;
            status_reg <= ST_DRAW_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            total_reg  <= total_next;
            valid_reg  <= valid_next;
            closed_reg <= closed_next;
            idx_reg    <= idx_next;
            ns_reg     <= ns_next;
            nl_reg     <= nl_next;
            strobe_reg <= strobe_next;
            index_reg  <= index_next;
            status_reg <= status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
        g_reg    <= g_next;
        ma_reg   <= ma_next;
        col_reg  <= col_next;
        r2_reg   <= r2_next;
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (ws_we)
            ws_mem[ws_wa] <= ws_wd;
        ws_rd <= ws_mem[ws_ra];
    end

    // scaled mass store
    always_ff @(posedge clk)
    begin
        if (mass_we)
            mass_mem[mass_wa] <= mass_wd;
        mass_rd <= mass_mem[mass_ra];
    end

    // probability and alias stores share an address
    always_ff @(posedge clk)
    begin
        if (pa_we)
        begin
            prob_mem[pa_wa]  <= prob_wd;
            alias_mem[pa_wa] <= alias_wd;
        end
        prob_rd  <= prob_mem[pa_ra];
        alias_rd <= alias_mem[pa_ra];
    end

    // small and large stacks
    always_ff @(posedge clk)
    begin
        if (sm_we)
            small_mem[sm_wa] <= sm_wd;
        sm_rd <= small_mem[sm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lg_we)
            large_mem[lg_wa] <= lg_wd;
        lg_rd <= large_mem[lg_ra];
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = strobe_reg;
    assign sample_index = index_reg;
    assign status       = status_reg;

    // a draw only succeeds from a valid table
    a_draw_valid: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && status_reg == ST_DRAW_OK |-> valid_reg)
        else $error("draw answered without a valid table");

    // every status other than a draw carries index zero
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && status_reg != ST_DRAW_OK |-> index_reg == '0)
        else $error("nonzero index on a non-draw result");

    // stacks never hold more than the set
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ns_reg + nl_reg) <= cnt_reg)
        else $error("stack depth exceeds entry count");

    // a result always ends an item
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> state_reg == S_IDLE)
        else $error("result issued while still at work");

endmodule

// File: hw/rtl/ats_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ats_div
    import ats_pkg::*;
#(
    parameter int HI_W  = DEF_WEIGHT_BITS,
    parameter int DEN_W = DEF_WEIGHT_BITS + 10,
    parameter int Q_W   = DEF_FRAC_BITS + 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [HI_W-1:0]  num_hi,
    input  logic [Q_W-1:0]   num_lo,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo
);

    localparam int CW = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   sh_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    // trial subtract of the divisor from the shifted remainder
    assign trial = {rem_reg, sh_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(Q_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_W'(num_hi);
            sh_reg  <= num_lo;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            sh_reg  <= {sh_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the alias table sampler: directed rows, a store fill, then random load and draw traffic.
`timescale 1ns / 100ps

module tb;
    import ats_pkg::*;

    localparam int        N_MAX   = DEF_MAX_ENTRIES;
    localparam logic [63:0] P_ONE = 64'h1_0000_0000;

    typedef struct {
        logic        cmd;
        logic [31:0] weight;
        logic        last;
        logic [31:0] ran1;
        logic [31:0] ran2;
        bit          fixed;
        logic [9:0]  fix_index;
        status_t     fix_status;
    } cmd_row_t;

    typedef struct {
        logic [9:0] index;
        status_t    status;
    } draw_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [31:0] weight;
    logic        last;
    logic [31:0] ran1;
    logic [31:0] ran2;
    logic        strobe;
    logic [9:0]  sample_index;
    status_t     status;

    // Predictor state
    logic [31:0] w_store [N_MAX];
    logic [63:0] mass    [N_MAX];
    logic [63:0] accept  [N_MAX];
    logic [9:0]  alias_of[N_MAX];
    int          small_s [N_MAX];
    int          large_s [N_MAX];
    int          n_loaded;
    logic [63:0] w_total;
    bit          tbl_valid;
    bit          set_closed;

    draw_result_t pending_q[$];
    int           err_count;
    bit           calm;

    alias_table_sampler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .weight(weight), .last(last), .ran1(ran1), .ran2(ran2),
        .strobe(strobe), .sample_index(sample_index), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Build the alias table over the stored weights
    function automatic status_t build_alias();
        int ns;
        int nl;
        int a;
        int g;
        logic [127:0] num;
        ns = 0;
        nl = 0;
        set_closed = 1'b1;
        if (w_total == 0)
        begin
            tbl_valid = 1'b0;
            return ST_ALL_ZERO;
        end
        for (int i = 0; i < n_loaded; i++)
        begin
            num = (128'(w_store[i]) * 128'(n_loaded)) << 32;
            mass[i] = 64'(num / 128'(w_total));
        end
        for (int i = n_loaded - 1; i >= 0; i--)
        begin
            if (mass[i] < P_ONE) small_s[ns++] = i;
            else large_s[nl++] = i;
        end
        // Pair small entries with large ones
        while (ns > 0 && nl > 0)
        begin
            a = small_s[--ns];
            g = large_s[--nl];
            accept[a] = mass[a];
            alias_of[a] = 10'(g);
            mass[g] = mass[g] + mass[a] - P_ONE;
            if (mass[g] < P_ONE) small_s[ns++] = g;
            else large_s[nl++] = g;
        end
        while (nl > 0)
        begin
            a = large_s[--nl];
            accept[a] = P_ONE;
            alias_of[a] = 10'(a);
        end
        while (ns > 0)
        begin
            a = small_s[--ns];
            accept[a] = P_ONE;
            alias_of[a] = 10'(a);
        end
        tbl_valid = 1'b1;
        return ST_BUILD_DONE;
    endfunction

    // Advance the predictor by one transfer; returns whether a result follows
    function automatic bit predict_sample(input cmd_row_t r, output draw_result_t res);
        bit dropped;
        logic [63:0] col;
        dropped = 1'b0;
        res.index = '0;
        if (r.cmd == CMD_LOAD)
        begin
            if (set_closed)
            begin
                n_loaded = 0;
                w_total = 0;
                tbl_valid = 1'b0;
                set_closed = 1'b0;
            end
            if (n_loaded < N_MAX)
            begin
                w_store[n_loaded] = r.weight;
                n_loaded++;
                w_total += 64'(r.weight);
            end
            else
                dropped = 1'b1;
            if (r.last)
            begin
                res.status = build_alias();
                return 1'b1;
            end
            res.status = ST_DROPPED;
            return dropped;
        end
        if (!tbl_valid || n_loaded == 0)
        begin
            res.status = ST_NO_TABLE;
            return 1'b1;
        end
        col = (64'(n_loaded) * 64'(r.ran1)) >> 32;
        if (col >= 64'(n_loaded)) col = 64'(n_loaded - 1);
        res.status = ST_DRAW_OK;
        res.index = (64'(r.ran2) < accept[col]) ? 10'(col) : alias_of[col];
        return 1'b1;
    endfunction

    // Present one command and hold it until the transfer
    task automatic send_cmd(input cmd_row_t r);
        draw_result_t res;
        if (!calm && $urandom_range(99) < 18)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start  <= 1'b1;
        cmd    <= r.cmd;
        weight <= r.weight;
        last   <= r.last;
        ran1   <= r.ran1;
        ran2   <= r.ran2;
        do @(posedge clk); while (busy);
        if (predict_sample(r, res))
        begin
            if (r.fixed)
            begin
                res.index = r.fix_index;
                res.status = r.fix_status;
            end
            pending_q.insert(pending_q.size(), res);
        end
    endtask

    function automatic cmd_row_t mk(input logic c, input logic [31:0] w, input logic l,
                                    input logic [31:0] a, input logic [31:0] b);
        cmd_row_t r;
        r.cmd = c;
        r.weight = w;
        r.last = l;
        r.ran1 = a;
        r.ran2 = b;
        r.fixed = 1'b0;
        r.fix_index = '0;
        r.fix_status = ST_DRAW_OK;
        return r;
    endfunction

    function automatic cmd_row_t mkx(input logic c, input logic [31:0] w, input logic l,
                                     input status_t st, input logic [9:0] idx);
        cmd_row_t r;
        r = mk(c, w, l, 32'h0, 32'h0);
        r.fixed = 1'b1;
        r.fix_status = st;
        r.fix_index = idx;
        return r;
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 16);
            default: return $urandom;
        endcase
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_q.size() == 0)
                report("unexpected result, status", 32'(status), 0);
            else
            begin
                if (status !== pending_q[0].status)
                    report("status", 32'(status), 32'(pending_q[0].status));
                if (sample_index !== pending_q[0].index)
                    report("sample_index", 32'(sample_index), 32'(pending_q[0].index));
                void'(pending_q.pop_front());
            end
        end
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        cmd_row_t dir_rows[$];
        int sent;
        int n_set;
        bit zeros;
        bit paused;

        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_LOAD;
        weight = '0;
        last = 1'b0;
        ran1 = '0;
        ran2 = '0;
        err_count = 0;
        calm = 1'b0;
        n_loaded = 0;
        w_total = 0;
        tbl_valid = 1'b0;
        set_closed = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: empty table, all-zero set, extremes, new set after build
        dir_rows = {dir_rows, mkx(CMD_DRAW, 32'h0, 1'b0, ST_NO_TABLE, 10'd0)};
        dir_rows = {dir_rows, mkx(CMD_LOAD, 32'h0, 1'b1, ST_ALL_ZERO, 10'd0)};
        dir_rows = {dir_rows, mkx(CMD_DRAW, 32'h0, 1'b0, ST_NO_TABLE, 10'd0)};
        dir_rows = {dir_rows, mk(CMD_LOAD, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0)};
        dir_rows = {dir_rows, mk(CMD_LOAD, 32'h0, 1'b0, 32'h0, 32'h0)};
        dir_rows = {dir_rows, mkx(CMD_LOAD, 32'h1, 1'b1, ST_BUILD_DONE, 10'd0)};
        dir_rows = {dir_rows, mk(CMD_DRAW, 32'h0, 1'b0, 32'h0, 32'h0)};
        dir_rows = {dir_rows, mk(CMD_DRAW, 32'h0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF)};
        dir_rows = {dir_rows, mk(CMD_DRAW, 32'h0, 1'b0, 32'h5555_5555, 32'hFFFF_FFFF)};
        dir_rows = {dir_rows, mk(CMD_DRAW, 32'h0, 1'b0, 32'hAAAA_AAAA, 32'h0)};
        dir_rows = {dir_rows, mk(CMD_LOAD, 32'h3, 1'b0, 32'h0, 32'h0)};
        dir_rows = {dir_rows, mkx(CMD_DRAW, 32'h0, 1'b0, ST_NO_TABLE, 10'd0)};
        dir_rows = {dir_rows, mk(CMD_LOAD, 32'h1, 1'b0, 32'h0, 32'h0)};
        dir_rows = {dir_rows, mkx(CMD_LOAD, 32'h0, 1'b1, ST_BUILD_DONE, 10'd0)};
        dir_rows = {dir_rows, mk(CMD_DRAW, 32'h0, 1'b0, 32'hC000_0000, 32'h8000_0000)};
        dir_rows = {dir_rows, mk(CMD_DRAW, 32'h0, 1'b0, 32'hFFFF_FFFF, 32'h0)};
        dir_rows = {dir_rows, mkx(CMD_LOAD, 32'h5, 1'b1, ST_BUILD_DONE, 10'd0)};
        dir_rows = {dir_rows, mkx(CMD_DRAW, 32'h0, 1'b0, ST_DRAW_OK, 10'd0)};
        foreach (dir_rows[i]) send_cmd(dir_rows[i]);

        // Fill the store, then one dropped load and a dropped last load
        for (int i = 0; i < N_MAX; i++)
            send_cmd(mk(CMD_LOAD, rand_weight(), 1'b0, 32'h0, 32'h0));
        send_cmd(mkx(CMD_LOAD, 32'h7, 1'b0, ST_DROPPED, 10'd0));
        send_cmd(mkx(CMD_LOAD, 32'h9, 1'b1, ST_BUILD_DONE, 10'd0));
        repeat (6) send_cmd(mk(CMD_DRAW, 32'h0, 1'b0, $urandom, $urandom));

        // Random sets of small size, each followed by a burst of draws
        sent = 0;
        paused = 1'b0;
        while (sent < 200)
        begin
            calm = (sent >= 60 && sent < 140);
            if (!paused && sent >= 30)
            begin
                // Hold off until the block has drained
                paused = 1'b1;
                start <= 1'b0;
                wait (pending_q.size() == 0);
                @(posedge clk);
            end
            n_set = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            zeros = ($urandom_range(11) == 0);
            for (int i = 0; i < n_set; i++)
            begin
                send_cmd(mk(CMD_LOAD, zeros ? 32'h0 : rand_weight(), i == n_set - 1,
                            $urandom, $urandom));
                sent++;
                // Noise: a draw in the middle of a set
                if ($urandom_range(15) == 0)
                begin
                    send_cmd(mk(CMD_DRAW, $urandom, 1'($urandom_range(1)), $urandom, $urandom));
                    sent++;
                end
            end
            repeat ($urandom_range(2, 10))
            begin
                send_cmd(mk(CMD_DRAW, $urandom, 1'($urandom_range(1)), $urandom, $urandom));
                sent++;
            end
        end
        calm = 1'b0;
        start <= 1'b0;

        wait (pending_q.size() == 0);
        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ats_pkg.sv
hw/rtl/ats_div.sv
hw/rtl/alias_table_sampler.sv
tb/tb.sv
